FILE: src/pdb_pkg.sv
// ----------------------------------------------------------------------------
// pdb_pkg: shared definitions for the pixel doubler blit
// Field widths, operation and mode codes, register indexes and the structs
// passed between the pipeline stages.
// ----------------------------------------------------------------------------
package pdb_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int ADDRESS_BITS_DEF  = 32;

   localparam int PIXEL_BITS   = 16;
   localparam int INDEX_BITS   = 8;
   localparam int WORD_BITS    = 32;
   localparam int PITCH_BITS   = 16;
   localparam int SIZE_BITS    = 12;
   localparam int OFFSET_BITS  = 16;
   localparam int SHIFTS_BITS  = 15;
   localparam int CSR_IDX_BITS = 3;
   localparam int ELEM_BITS    = 3;

   // Operation carried by an input item.
   typedef enum logic {
      OP_PALETTE = 1'b0,
      OP_PIXEL   = 1'b1
   } op_type;

   // Pixel conversion modes.
   typedef enum logic [1:0] {
      MODE_PAL32  = 2'd0,
      MODE_PAL16  = 2'd1,
      MODE_RGB555 = 2'd2,
      MODE_RAW16  = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PIXEL_MODE     = 3'd0,
      CSR_SURFACE_BASE   = 3'd1,
      CSR_DEST_PITCH     = 3'd2,
      CSR_FRAME_WIDTH    = 3'd3,
      CSR_FRAME_HEIGHT   = 3'd4,
      CSR_TOP_OFFSET     = 3'd5,
      CSR_LEFT_OFFSET    = 3'd6,
      CSR_CHANNEL_SHIFTS = 3'd7
   } csr_index_type;

   // Order of the four writes of a 2x2 block. Bit 0 adds the pitch,
   // bit 1 adds the element size.
   localparam logic [1:0] BEAT_TOP_LEFT     = 2'd0;
   localparam logic [1:0] BEAT_BOTTOM_LEFT  = 2'd1;
   localparam logic [1:0] BEAT_TOP_RIGHT    = 2'd2;
   localparam logic [1:0] BEAT_BOTTOM_RIGHT = 2'd3;

   localparam logic [ELEM_BITS-1:0] ELEM_WIDE   = 3'd4;
   localparam logic [ELEM_BITS-1:0] ELEM_NARROW = 3'd2;

   // Configuration seen by the pixel stage.
   typedef struct packed {
      mode_type                pixel_mode;
      logic [PITCH_BITS-1:0]   dest_pitch;
      logic [SIZE_BITS-1:0]    frame_width;
      logic [SIZE_BITS-1:0]    frame_height;
      logic [SHIFTS_BITS-1:0]  channel_shifts;
   } cfg_type;

   // A converted pixel handed from the pixel stage to the write emitter.
   typedef struct packed {
      logic                    load;
      logic [WORD_BITS-1:0]    data;
      logic [PITCH_BITS-1:0]   pitch_step;
      logic [ELEM_BITS-1:0]    elem_size;
      logic                    end_of_frame;
   } pix_type;

endpackage

FILE: src/pdb_req_if.sv
// ----------------------------------------------------------------------------
// pdb_req_if: input item channel
// Valid/ready channel carrying palette loads and source pixels.
// ----------------------------------------------------------------------------
interface pdb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                op;
   logic [pdb_pkg::PIXEL_BITS-1:0]      pixel_value;
   logic [pdb_pkg::INDEX_BITS-1:0]      palette_index;
   logic [pdb_pkg::WORD_BITS-1:0]       palette_entry;

   modport source (output valid, output op, output pixel_value, output palette_index,
                   output palette_entry, input ready);
   modport sink   (input valid, input op, input pixel_value, input palette_index,
                   input palette_entry, output ready);
endinterface

FILE: src/pdb_rsp_if.sv
// ----------------------------------------------------------------------------
// pdb_rsp_if: memory write channel
// Valid/ready channel carrying one destination write per item.
// ----------------------------------------------------------------------------
interface pdb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pdb_pkg::WORD_BITS-1:0]       write_address;
   logic [pdb_pkg::WORD_BITS-1:0]       write_data;
   logic                                last_of_pixel;
   logic                                end_of_frame;

   modport source (output valid, output write_address, output write_data,
                   output last_of_pixel, output end_of_frame, input ready);
   modport sink   (input valid, input write_address, input write_data,
                   input last_of_pixel, input end_of_frame, output ready);
endinterface

FILE: src/pdb_csr_if.sv
// ----------------------------------------------------------------------------
// pdb_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pdb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pdb_pkg::CSR_IDX_BITS-1:0]    index;
   logic [pdb_pkg::WORD_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/pdb_ram.sv
// ----------------------------------------------------------------------------
// pdb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module pdb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pdb_csr.sv
// ----------------------------------------------------------------------------
// pdb_csr: configuration registers
// Holds the registers and keeps a registered copy of the frame start address.
// ----------------------------------------------------------------------------
module pdb_csr #(
   parameter int ADDRESS_BITS = pdb_pkg::ADDRESS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdb_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [pdb_pkg::WORD_BITS-1:0]       csr_data,
   output pdb_pkg::cfg_type                    cfg,
   output logic [ADDRESS_BITS-1:0]             start_addr
);

   pdb_pkg::mode_type                    pixel_mode_ff;
   logic [pdb_pkg::WORD_BITS-1:0]        surface_base_ff;
   logic [pdb_pkg::PITCH_BITS-1:0]       dest_pitch_ff;
   logic [pdb_pkg::SIZE_BITS-1:0]        frame_width_ff;
   logic [pdb_pkg::SIZE_BITS-1:0]        frame_height_ff;
   logic [pdb_pkg::OFFSET_BITS-1:0]      top_offset_ff;
   logic [pdb_pkg::OFFSET_BITS-1:0]      left_offset_ff;
   logic [pdb_pkg::SHIFTS_BITS-1:0]      channel_shifts_ff;

   logic [ADDRESS_BITS-1:0] start_ff;
   logic [ADDRESS_BITS-1:0] start_in;
   logic [ADDRESS_BITS-1:0] top_diff;
   logic [ADDRESS_BITS-1:0] left_diff;
   logic [ADDRESS_BITS-1:0] row_bytes;
   logic [ADDRESS_BITS-1:0] col_bytes;
   logic                    wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff     <= pdb_pkg::MODE_PAL32;
         surface_base_ff   <= '0;
         dest_pitch_ff     <= '0;
         frame_width_ff    <= pdb_pkg::SIZE_BITS'(1);
         frame_height_ff   <= pdb_pkg::SIZE_BITS'(1);
         top_offset_ff     <= '0;
         left_offset_ff    <= '0;
         channel_shifts_ff <= '0;
      end else if (csr_valid) begin
         case (pdb_pkg::csr_index_type'(csr_index))
            pdb_pkg::CSR_PIXEL_MODE:
               pixel_mode_ff <= pdb_pkg::mode_type'(csr_data[1:0]);
            pdb_pkg::CSR_SURFACE_BASE:   surface_base_ff   <= csr_data;
            pdb_pkg::CSR_DEST_PITCH:     dest_pitch_ff     <= csr_data[15:0];
            pdb_pkg::CSR_FRAME_WIDTH:    frame_width_ff    <= csr_data[11:0];
            pdb_pkg::CSR_FRAME_HEIGHT:   frame_height_ff   <= csr_data[11:0];
            pdb_pkg::CSR_TOP_OFFSET:     top_offset_ff     <= csr_data[15:0];
            pdb_pkg::CSR_LEFT_OFFSET:    left_offset_ff    <= csr_data[15:0];
            pdb_pkg::CSR_CHANNEL_SHIFTS: channel_shifts_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Start address: base + (top - height/2) * pitch + (left - width/2) * size.
   always_comb begin
      wide      = (pixel_mode_ff == pdb_pkg::MODE_PAL32) ||
                  (pixel_mode_ff == pdb_pkg::MODE_RGB555);
      top_diff  = ADDRESS_BITS'(top_offset_ff) - ADDRESS_BITS'(frame_height_ff >> 1);
      left_diff = ADDRESS_BITS'(left_offset_ff) - ADDRESS_BITS'(frame_width_ff >> 1);
      row_bytes = ADDRESS_BITS'(top_diff * ADDRESS_BITS'(dest_pitch_ff));
      col_bytes = wide ? (left_diff << 2) : (left_diff << 1);
      start_in  = ADDRESS_BITS'(surface_base_ff) + row_bytes + col_bytes;
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

   assign start_addr         = start_ff;
   assign cfg.pixel_mode     = pixel_mode_ff;
   assign cfg.dest_pitch     = dest_pitch_ff;
   assign cfg.frame_width    = frame_width_ff;
   assign cfg.frame_height   = frame_height_ff;
   assign cfg.channel_shifts = channel_shifts_ff;

endmodule

FILE: src/pdb_pixel.sv
// ----------------------------------------------------------------------------
// pdb_pixel: input stage
// Takes items, loads the palette, reads it for pixels, converts the pixel
// and works out the block address while tracking the raster position.
// ----------------------------------------------------------------------------
module pdb_pixel #(
   parameter int PALETTE_DEPTH = pdb_pkg::PALETTE_DEPTH_DEF,
   parameter int ADDRESS_BITS  = pdb_pkg::ADDRESS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [pdb_pkg::PIXEL_BITS-1:0]      req_pixel_value,
   input  logic [pdb_pkg::INDEX_BITS-1:0]      req_palette_index,
   input  logic [pdb_pkg::WORD_BITS-1:0]       req_palette_entry,
   input  pdb_pkg::cfg_type                    cfg,
   input  logic [ADDRESS_BITS-1:0]             start_addr,
   input  logic                                emit_free,
   output pdb_pkg::pix_type                    pix,
   output logic [ADDRESS_BITS-1:0]             pix_addr
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);

   logic                                  accept;
   logic                                  move;
   logic                                  wr_ok;
   logic                                  rd_ok;
   logic [pdb_pkg::INDEX_BITS-1:0]        rd_index;
   logic [pdb_pkg::WORD_BITS-1:0]         rd_data;

   logic                                  held_ff;
   logic                                  held_in;
   logic                                  rd_ok_ff;
   logic [pdb_pkg::PIXEL_BITS-1:0]        value_ff;

   logic [pdb_pkg::SIZE_BITS-1:0]         col_ff, col_in;
   logic [pdb_pkg::SIZE_BITS-1:0]         row_ff, row_in;
   logic [ADDRESS_BITS-1:0]               line_ff, line_in;

   logic                                  wide;
   logic                                  eol;
   logic                                  eof;
   logic [ADDRESS_BITS-1:0]               line_start;
   logic [pdb_pkg::PITCH_BITS-1:0]        pitch_step;
   logic [pdb_pkg::SIZE_BITS+2:0]         col_bytes;
   logic [pdb_pkg::WORD_BITS-1:0]         word;
   logic [pdb_pkg::WORD_BITS-1:0]         data;
   logic [pdb_pkg::WORD_BITS-1:0]         blue, green, red;

   assign move      = held_ff && emit_free;
   assign req_ready = !held_ff || move;
   assign accept    = req_valid && req_ready;

   // Out-of-range palette writes are dropped and out-of-range reads give zero.
   assign wr_ok    = ({1'b0, req_palette_index} < 9'(PALETTE_DEPTH));
   assign rd_index = (cfg.pixel_mode == pdb_pkg::MODE_PAL16) ?
                     {1'b0, req_pixel_value[7:1]} : req_pixel_value[7:0];
   assign rd_ok    = ({1'b0, rd_index} < 9'(PALETTE_DEPTH));

   pdb_ram #(
      .WIDTH (pdb_pkg::WORD_BITS),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_op == pdb_pkg::OP_PALETTE) && wr_ok),
      .wr_addr (req_palette_index[PAL_AW-1:0]),
      .wr_data (req_palette_entry),
      .rd_en   (accept && (req_op == pdb_pkg::OP_PIXEL)),
      .rd_addr (rd_index[PAL_AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      held_in = held_ff;
      if (move) begin
         held_in = 1'b0;
      end
      if (accept && (req_op == pdb_pkg::OP_PIXEL)) begin
         held_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_op == pdb_pkg::OP_PIXEL)) begin
         rd_ok_ff <= rd_ok;
         value_ff <= req_pixel_value;
      end
   end

   // Pixel conversion.
   always_comb begin
      word  = rd_ok_ff ? rd_data : '0;
      blue  = {24'd0, value_ff[4:0], 3'd0} << cfg.channel_shifts[4:0];
      green = {24'd0, value_ff[9:5], 3'd0} << cfg.channel_shifts[9:5];
      red   = {24'd0, value_ff[14:10], 3'd0} << cfg.channel_shifts[14:10];
      case (cfg.pixel_mode)
         pdb_pkg::MODE_PAL32:  data = word;
         pdb_pkg::MODE_PAL16:  data = value_ff[0] ? {16'd0, word[31:16]} :
                                                    {16'd0, word[15:0]};
         pdb_pkg::MODE_RGB555: data = blue | green | red;
         pdb_pkg::MODE_RAW16:  data = {16'd0, value_ff};
         default:              data = {16'd0, value_ff};
      endcase
   end

   // Raster position and block address.
   always_comb begin
      wide       = (cfg.pixel_mode == pdb_pkg::MODE_PAL32) ||
                   (cfg.pixel_mode == pdb_pkg::MODE_RGB555);
      line_start = ((col_ff == '0) && (row_ff == '0)) ? start_addr : line_ff;
      pitch_step = wide ? {cfg.dest_pitch[15:2], 2'd0} : {cfg.dest_pitch[15:1], 1'b0};
      col_bytes  = wide ? {col_ff, 3'd0} : {1'b0, col_ff, 2'd0};
      pix_addr   = line_start + ADDRESS_BITS'(col_bytes);
      eol        = ((13'(col_ff) + 13'd1) >= 13'(cfg.frame_width));
      eof        = eol && ((13'(row_ff) + 13'd1) >= 13'(cfg.frame_height));

      col_in  = col_ff;
      row_in  = row_ff;
      line_in = line_ff;
      if (move) begin
         if (eol) begin
            col_in  = '0;
            line_in = line_start + ADDRESS_BITS'({pitch_step, 1'b0});
            row_in  = eof ? '0 : row_ff + pdb_pkg::SIZE_BITS'(1);
         end else begin
            col_in  = col_ff + pdb_pkg::SIZE_BITS'(1);
            line_in = line_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

   assign pix.load         = move;
   assign pix.data         = data;
   assign pix.pitch_step   = pitch_step;
   assign pix.elem_size    = wide ? pdb_pkg::ELEM_WIDE : pdb_pkg::ELEM_NARROW;
   assign pix.end_of_frame = eof;

`ifndef SYNTH
   // A pixel waiting for the emitter stays in the stage.
   a_held_until_moved: assert property (@(posedge clock) disable iff (reset)
      (held_ff && !emit_free) |=> held_ff)
      else $error("pixel stage dropped a waiting pixel");

   // The last pixel of a frame returns the raster position to the origin.
   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      (move && eof) |=> ((col_ff == '0) && (row_ff == '0)))
      else $error("raster position did not wrap at end of frame");
`endif

endmodule

FILE: src/pdb_emit.sv
// ----------------------------------------------------------------------------
// pdb_emit: write emitter
// Holds one converted pixel; sends its 2x2 block writes one per ready cycle.
// ----------------------------------------------------------------------------
module pdb_emit #(
   parameter int ADDRESS_BITS = pdb_pkg::ADDRESS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pdb_pkg::pix_type                    pix,
   input  logic [ADDRESS_BITS-1:0]             pix_addr,
   output logic                                emit_free,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pdb_pkg::WORD_BITS-1:0]       rsp_write_address,
   output logic [pdb_pkg::WORD_BITS-1:0]       rsp_write_data,
   output logic                                rsp_last_of_pixel,
   output logic                                rsp_end_of_frame
);

   logic                    busy_ff, busy_in;
   logic [1:0]              beat_ff, beat_in;
   logic [ADDRESS_BITS-1:0] addr_ff;
   pdb_pkg::pix_type        pix_ff;
   logic                    taken;
   logic [ADDRESS_BITS-1:0] beat_addr;

   assign taken     = busy_ff && rsp_ready;
   assign emit_free = !busy_ff || (rsp_ready && (beat_ff == pdb_pkg::BEAT_BOTTOM_RIGHT));

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (taken) begin
         if (beat_ff == pdb_pkg::BEAT_BOTTOM_RIGHT) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
      if (pix.load) begin
         busy_in = 1'b1;
         beat_in = pdb_pkg::BEAT_TOP_LEFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= pdb_pkg::BEAT_TOP_LEFT;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix.load) begin
         addr_ff <= pix_addr;
         pix_ff  <= pix;
      end
   end

   // Beat bit 0 steps down a row, bit 1 steps right one element.
   assign beat_addr = addr_ff
                    + (beat_ff[0] ? ADDRESS_BITS'(pix_ff.pitch_step) : '0)
                    + (beat_ff[1] ? ADDRESS_BITS'(pix_ff.elem_size) : '0);

   assign rsp_valid         = busy_ff;
   assign rsp_write_address = pdb_pkg::WORD_BITS'(beat_addr);
   assign rsp_write_data    = pix_ff.data;
   assign rsp_last_of_pixel = (beat_ff == pdb_pkg::BEAT_BOTTOM_RIGHT);
   assign rsp_end_of_frame  = pix_ff.end_of_frame;

`ifndef SYNTH
   // A new pixel is loaded only when the previous block is done.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      pix.load |-> emit_free)
      else $error("pixel loaded over a block still in progress");

   // A loaded pixel starts at the top-left write.
   a_load_starts_block: assert property (@(posedge clock) disable iff (reset)
      pix.load |=> (busy_ff && (beat_ff == pdb_pkg::BEAT_TOP_LEFT)))
      else $error("block did not start at the top-left write");

   // Accepted writes other than the last advance the beat by one.
   a_beat_advances: assert property (@(posedge clock) disable iff (reset)
      (taken && (beat_ff != pdb_pkg::BEAT_BOTTOM_RIGHT)) |=>
         (beat_ff == $past(beat_ff) + 2'd1))
      else $error("write order skipped or repeated a beat");
`endif

endmodule

FILE: src/pixel_doubler_blit_top.sv
// ----------------------------------------------------------------------------
// pixel_doubler_blit_top: 2x nearest-neighbor upscaling blit with palette
// Converts source pixels by mode and writes each one as a 2x2 block.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   --------  ---------  ---------------------------------------------------
//   req_bus   in         palette loads and source pixels, raster order
//   rsp_bus   out        destination writes: address, data, last, end of frame
//   csr_bus   in         register index and write data
//
// A source pixel produces four writes, one per cycle while the write channel
// is ready; the single write channel limits how fast pixels are taken.
// Palette loads produce no writes and are taken one per cycle unless a pixel
// waits for the emitter. The first write of a pixel leaves once it has passed
// the registered palette read and the emitter's write register.
// Reset is synchronous and clears the counters and handshake state; the
// palette holds no valid bits and needs no clearing pass.
// A stalled write channel backs up through the emitter and the input stage;
// one more pixel can be accepted while a block is still being written.
//
module pixel_doubler_blit_top #(
   parameter int PALETTE_DEPTH = pdb_pkg::PALETTE_DEPTH_DEF,
   parameter int ADDRESS_BITS  = pdb_pkg::ADDRESS_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pdb_req_if.sink   req_bus,
   pdb_rsp_if.source rsp_bus,
   pdb_csr_if.sink   csr_bus
);

   pdb_pkg::cfg_type        cfg;
   pdb_pkg::pix_type        pix;
   logic [ADDRESS_BITS-1:0] start_addr;
   logic [ADDRESS_BITS-1:0] pix_addr;
   logic                    emit_free;

   // Configuration registers. The frame start address is kept registered
   // here and picked up by the input stage at the first pixel of a frame.
   pdb_csr #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_bus.valid),
      .csr_ready  (csr_bus.ready),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .cfg        (cfg),
      .start_addr (start_addr)
   );

   // Input stage: palette memory, conversion and raster address.
   pdb_pixel #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .ADDRESS_BITS  (ADDRESS_BITS)
   ) u_pixel (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_op            (req_bus.op),
      .req_pixel_value   (req_bus.pixel_value),
      .req_palette_index (req_bus.palette_index),
      .req_palette_entry (req_bus.palette_entry),
      .cfg               (cfg),
      .start_addr        (start_addr),
      .emit_free         (emit_free),
      .pix               (pix),
      .pix_addr          (pix_addr)
   );

   // Write emitter: top-left, bottom-left, top-right, bottom-right.
   pdb_emit #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .pix               (pix),
      .pix_addr          (pix_addr),
      .emit_free         (emit_free),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_write_address (rsp_bus.write_address),
      .rsp_write_data    (rsp_bus.write_data),
      .rsp_last_of_pixel (rsp_bus.last_of_pixel),
      .rsp_end_of_frame  (rsp_bus.end_of_frame)
   );

endmodule

FILE: dv/pixel_doubler_blit_top_tb.sv
// ----------------------------------------------------------------------------
// pixel_doubler_blit_top_tb: self-checking bench for the 2x upscaling blit
// Drives palette loads and source pixels and programs the registers between
// phases. A local model of the blit predicts four writes per pixel, and every
// write that leaves the block is compared, field by field, with the oldest
// prediction. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module pixel_doubler_blit_top_tb;

   // One destination write as the block reports it.
   typedef struct packed {
      logic [pdb_pkg::WORD_BITS-1:0] address;
      logic [pdb_pkg::WORD_BITS-1:0] data;
      logic                          last_of_pixel;
      logic                          end_of_frame;
   } blit_write_type;

   logic clock;
   logic reset;

   pdb_req_if req_bus ();
   pdb_rsp_if rsp_bus ();
   pdb_csr_if csr_bus ();

   pixel_doubler_blit_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Register shadow of the block's configuration, at reset values.
   pdb_pkg::mode_type               cfg_mode   = pdb_pkg::MODE_PAL32;
   logic [pdb_pkg::WORD_BITS-1:0]   cfg_base   = '0;
   logic [pdb_pkg::PITCH_BITS-1:0]  cfg_pitch  = '0;
   logic [pdb_pkg::SIZE_BITS-1:0]   cfg_width  = 12'd1;
   logic [pdb_pkg::SIZE_BITS-1:0]   cfg_height = 12'd1;
   logic [pdb_pkg::OFFSET_BITS-1:0] cfg_top    = '0;
   logic [pdb_pkg::OFFSET_BITS-1:0] cfg_left   = '0;
   logic [pdb_pkg::SHIFTS_BITS-1:0] cfg_shifts = '0;

   // Predicted raster state. The line base is recomputed at the first pixel of
   // every frame, so its reset value never matters.
   logic [pdb_pkg::WORD_BITS-1:0] palette_words [256];
   bit                            word_loaded   [256];
   int                            loaded_words  [$];
   logic [pdb_pkg::SIZE_BITS-1:0] column_pos = '0;
   logic [pdb_pkg::SIZE_BITS-1:0] row_pos    = '0;
   logic [pdb_pkg::WORD_BITS-1:0] line_base  = '0;

   blit_write_type expected_writes [$];
   blit_write_type seen_write;
   blit_write_type due_write;
   int             fail_count = 0;

   // Handshake pacing, in percent of cycles spent idle.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   // A long write-side stall is requested here and counted down by the
   // ready driver.
   int rsp_hold_request = 0;
   int rsp_hold_left    = 0;

   // -------------------------------------------------------------------------
   // Clock, and every block input at a known value from time zero.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.op            = pdb_pkg::OP_PALETTE;
      req_bus.pixel_value   = '0;
      req_bus.palette_index = '0;
      req_bus.palette_entry = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = pdb_pkg::CSR_PIXEL_MODE;
      csr_bus.data          = '0;
   end

   // -------------------------------------------------------------------------
   // Write-side ready. It changes only at the falling edge. A pending hold
   // request turns into a run of cycles with ready low, which lets the block
   // fill up and push back on its input.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Prediction.
   // -------------------------------------------------------------------------

   // Bytes per destination element: wide in the 32-bit modes.
   function automatic logic [pdb_pkg::WORD_BITS-1:0] element_bytes();
      return (cfg_mode == pdb_pkg::MODE_PAL32 || cfg_mode == pdb_pkg::MODE_RGB555) ?
             32'd4 : 32'd2;
   endfunction

   // First address of a frame: half the frame size is taken off both offsets,
   // and everything wraps at 32 bits.
   function automatic logic [pdb_pkg::WORD_BITS-1:0] frame_origin();
      logic [pdb_pkg::WORD_BITS-1:0] rows;
      logic [pdb_pkg::WORD_BITS-1:0] cols;
      rows = 32'(cfg_top) - 32'(cfg_height >> 1);
      cols = 32'(cfg_left) - 32'(cfg_width >> 1);
      return cfg_base + rows * 32'(cfg_pitch) + cols * element_bytes();
   endfunction

   function automatic logic [pdb_pkg::WORD_BITS-1:0] convert_pixel(
      logic [pdb_pkg::PIXEL_BITS-1:0] value);
      logic [pdb_pkg::WORD_BITS-1:0] word;
      logic [pdb_pkg::WORD_BITS-1:0] blue;
      logic [pdb_pkg::WORD_BITS-1:0] green;
      logic [pdb_pkg::WORD_BITS-1:0] red;
      case (cfg_mode)
         pdb_pkg::MODE_PAL32: begin
            return palette_words[value[7:0]];
         end
         pdb_pkg::MODE_PAL16: begin
            // Halfword i of the palette: odd indexes take the upper half.
            word = palette_words[{1'b0, value[7:1]}];
            return value[0] ? {16'h0, word[31:16]} : {16'h0, word[15:0]};
         end
         pdb_pkg::MODE_RGB555: begin
            // Each 5-bit channel sits at bits 7:3 before its own shift, and
            // bits pushed past the top are dropped.
            blue  = {24'h0, value[4:0], 3'b000} << cfg_shifts[4:0];
            green = {24'h0, value[9:5], 3'b000} << cfg_shifts[9:5];
            red   = {24'h0, value[14:10], 3'b000} << cfg_shifts[14:10];
            return blue | green | red;
         end
         default: begin
            return {16'h0, value};
         end
      endcase
   endfunction

   // Applies one accepted input item to the prediction. A palette load only
   // updates the store; a pixel queues its four writes.
   task automatic predict_blit_writes(pdb_pkg::op_type op,
                                      logic [pdb_pkg::PIXEL_BITS-1:0] value,
                                      logic [pdb_pkg::INDEX_BITS-1:0] index,
                                      logic [pdb_pkg::WORD_BITS-1:0] entry);
      logic [pdb_pkg::WORD_BITS-1:0] elem;
      logic [pdb_pkg::WORD_BITS-1:0] row_step;
      logic [pdb_pkg::WORD_BITS-1:0] corner;
      logic [pdb_pkg::WORD_BITS-1:0] colour;
      logic                          line_done;
      logic                          frame_done;
      blit_write_type                beat;
      if (op == pdb_pkg::OP_PALETTE) begin
         palette_words[index] = entry;
         if (!word_loaded[index]) begin
            word_loaded[index] = 1'b1;
            loaded_words.push_back(int'(index));
         end
         return;
      end
      if (row_pos == 0 && column_pos == 0) line_base = frame_origin();
      elem       = element_bytes();
      row_step   = (32'(cfg_pitch) / elem) * elem;
      colour     = convert_pixel(value);
      line_done  = (32'(column_pos) + 32'd1) >= 32'(cfg_width);
      frame_done = line_done && ((32'(row_pos) + 32'd1) >= 32'(cfg_height));
      corner     = line_base + 32'd2 * elem * 32'(column_pos);
      // Beat order follows the package: bit 0 adds the row step, bit 1 the
      // element size.
      for (int k = 0; k < 4; k++) begin
         beat.address       = corner + (k[0] ? row_step : 32'd0) + (k[1] ? elem : 32'd0);
         beat.data          = colour;
         beat.last_of_pixel = (k == 3);
         beat.end_of_frame  = frame_done;
         expected_writes.push_back(beat);
      end
      if (line_done) begin
         column_pos = '0;
         line_base  = line_base + 32'd2 * row_step;
         row_pos    = frame_done ? '0 : row_pos + 1'b1;
      end else begin
         column_pos = column_pos + 1'b1;
      end
   endtask

   // -------------------------------------------------------------------------
   // Checking. Outputs are sampled at the rising edge; each accepted write is
   // matched against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_write = {rsp_bus.write_address, rsp_bus.write_data,
                       rsp_bus.last_of_pixel, rsp_bus.end_of_frame};
         if (expected_writes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected write: addr=%h data=%h last=%b eof=%b",
                        seen_write.address, seen_write.data,
                        seen_write.last_of_pixel, seen_write.end_of_frame);
         end else begin
            due_write = expected_writes.pop_front();
            if (seen_write !== due_write) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("write mismatch: expected addr=%h data=%h last=%b eof=%b, %s",
                           due_write.address, due_write.data, due_write.last_of_pixel,
                           due_write.end_of_frame,
                           $sformatf("got addr=%h data=%h last=%b eof=%b",
                                     seen_write.address, seen_write.data,
                                     seen_write.last_of_pixel, seen_write.end_of_frame));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers. Every task starts and ends at a falling edge.
   // -------------------------------------------------------------------------

   // Offers one item, idling first as the pacing asks, and predicts it at the
   // edge where it is taken. Valid stays high so that the next item can follow
   // directly.
   task automatic send_item(pdb_pkg::op_type op, logic [pdb_pkg::PIXEL_BITS-1:0] value,
                            logic [pdb_pkg::INDEX_BITS-1:0] index,
                            logic [pdb_pkg::WORD_BITS-1:0] entry);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.op            = op;
      req_bus.pixel_value   = value;
      req_bus.palette_index = index;
      req_bus.palette_entry = entry;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_blit_writes(op, value, index, entry);
      @(negedge clock);
   endtask

   // The unused fields of each item carry random bits, so the block has to
   // ignore them.
   task automatic load_palette(logic [pdb_pkg::INDEX_BITS-1:0] index,
                               logic [pdb_pkg::WORD_BITS-1:0] entry);
      send_item(pdb_pkg::OP_PALETTE, 16'($urandom_range(65535)), index, entry);
   endtask

   task automatic send_pixel(logic [pdb_pkg::PIXEL_BITS-1:0] value);
      send_item(pdb_pkg::OP_PIXEL, value, 8'($urandom_range(255)), $urandom);
   endtask

   // Random pixel for the current mode. Palette modes only read words that
   // were loaded before.
   function automatic logic [pdb_pkg::PIXEL_BITS-1:0] pick_pixel_value();
      logic [7:0] upper;
      int         word;
      upper = 8'($urandom_range(255));
      word  = loaded_words[$urandom_range(loaded_words.size() - 1)];
      case (cfg_mode)
         pdb_pkg::MODE_PAL32: begin
            return {upper, 8'(word)};
         end
         pdb_pkg::MODE_PAL16: begin
            // Halfword indexes reach only the lower half of the store.
            for (int tries = 0; tries < 16 && word >= 128; tries++)
               word = loaded_words[$urandom_range(loaded_words.size() - 1)];
            if (word >= 128) word = 0;
            return {upper, 7'(word), 1'($urandom_range(1))};
         end
         default: begin
            return 16'($urandom_range(65535));
         end
      endcase
   endfunction

   // Waits until every predicted write has arrived, or until the limit, and
   // then lets the pipeline settle after loads that produce no writes.
   task automatic drain_writes(int limit);
      int waited;
      waited        = 0;
      req_bus.valid = 1'b0;
      while (expected_writes.size() != 0 && waited < limit) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(pdb_pkg::csr_index_type index,
                            logic [pdb_pkg::WORD_BITS-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         pdb_pkg::CSR_PIXEL_MODE:     cfg_mode   = pdb_pkg::mode_type'(value[1:0]);
         pdb_pkg::CSR_SURFACE_BASE:   cfg_base   = value;
         pdb_pkg::CSR_DEST_PITCH:     cfg_pitch  = value[pdb_pkg::PITCH_BITS-1:0];
         pdb_pkg::CSR_FRAME_WIDTH:    cfg_width  = value[pdb_pkg::SIZE_BITS-1:0];
         pdb_pkg::CSR_FRAME_HEIGHT:   cfg_height = value[pdb_pkg::SIZE_BITS-1:0];
         pdb_pkg::CSR_TOP_OFFSET:     cfg_top    = value[pdb_pkg::OFFSET_BITS-1:0];
         pdb_pkg::CSR_LEFT_OFFSET:    cfg_left   = value[pdb_pkg::OFFSET_BITS-1:0];
         pdb_pkg::CSR_CHANNEL_SHIFTS: cfg_shifts = value[pdb_pkg::SHIFTS_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Drains the block, then writes all eight registers back to back.
   task automatic write_setup(pdb_pkg::mode_type mode, logic [31:0] base,
                              logic [15:0] pitch, logic [11:0] width,
                              logic [11:0] height, logic [15:0] top,
                              logic [15:0] left, logic [14:0] shifts);
      drain_writes(100000);
      csr_write(pdb_pkg::CSR_PIXEL_MODE, 32'(mode));
      csr_write(pdb_pkg::CSR_SURFACE_BASE, base);
      csr_write(pdb_pkg::CSR_DEST_PITCH, 32'(pitch));
      csr_write(pdb_pkg::CSR_FRAME_WIDTH, 32'(width));
      csr_write(pdb_pkg::CSR_FRAME_HEIGHT, 32'(height));
      csr_write(pdb_pkg::CSR_TOP_OFFSET, 32'(top));
      csr_write(pdb_pkg::CSR_LEFT_OFFSET, 32'(left));
      csr_write(pdb_pkg::CSR_CHANNEL_SHIFTS, 32'(shifts));
      csr_bus.valid = 1'b0;
   endtask

   // Frame sizes are mostly tiny so that frames wrap often; now and then a
   // zero or the largest size shows up.
   function automatic logic [11:0] pick_frame_size();
      case ($urandom_range(9))
         0:       return 12'd0;
         1:       return 12'hFFF;
         default: return 12'($urandom_range(1, 5));
      endcase
   endfunction

   task automatic write_random_setup();
      logic [15:0] pitch;
      logic [14:0] shifts;
      case ($urandom_range(3))
         0:       pitch = 16'($urandom_range(64));
         1:       pitch = 16'hFFFF;
         2:       pitch = 16'h0000;
         default: pitch = 16'($urandom_range(65535));
      endcase
      // Small shifts keep most channel bits visible; full-range ones test
      // the loss past bit 31.
      if ($urandom_range(1) != 0)
         shifts = 15'($urandom_range(32767));
      else
         shifts = {5'($urandom_range(3)), 5'($urandom_range(3)), 5'($urandom_range(3))};
      write_setup(pdb_pkg::mode_type'($urandom_range(3)), $urandom, pitch,
                  pick_frame_size(), pick_frame_size(), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), shifts);
   endtask

   // -------------------------------------------------------------------------
   // Tests.
   // -------------------------------------------------------------------------

   // With the reset configuration (palette to 32 bits, a one-pixel frame,
   // zero pitch and base) every pixel is a whole frame on its own.
   task automatic test_reset_configuration();
      load_palette(8'd0, 32'h0000_0000);
      load_palette(8'd1, 32'hFFFF_FFFF);
      load_palette(8'd127, 32'hA5C3_3C5A);
      load_palette(8'd255, 32'h8000_0001);
      send_pixel(16'hFF00);
      send_pixel(16'h00FF);
   endtask

   // Halfword lookup: even indexes take the low half of word i/2, odd ones
   // the high half. The odd pitch is cut down to a multiple of the element size.
   task automatic test_palette_halfwords();
      write_setup(pdb_pkg::MODE_PAL16, 32'h0000_1000, 16'h0101, 12'd2, 12'd2, 16'd4,
                  16'd3, 15'd0);
      send_pixel(16'h0000);
      send_pixel(16'h0003);
      send_pixel(16'hFFFE);
      send_pixel(16'h00FF);
   endtask

   // RGB555 with no shift, with the largest shifts (every channel bit falls
   // off), and with a spread of shifts; then the 16-bit copy.
   task automatic test_color_conversion();
      write_setup(pdb_pkg::MODE_RGB555, 32'h0, 16'h0010, 12'd4, 12'd4, 16'd0, 16'd0,
                  15'd0);
      send_pixel(16'h7FFF);
      send_pixel(16'h8000);
      write_setup(pdb_pkg::MODE_RGB555, 32'h0, 16'h0010, 12'd4, 12'd4, 16'd0, 16'd0,
                  15'h7FFF);
      send_pixel(16'hFFFF);
      write_setup(pdb_pkg::MODE_RGB555, 32'h0, 16'h0010, 12'd4, 12'd4, 16'd0, 16'd0,
                  {5'd16, 5'd8, 5'd0});
      send_pixel(16'h7FFF);
      write_setup(pdb_pkg::MODE_RAW16, 32'h0, 16'h0010, 12'd4, 12'd4, 16'd0, 16'd0,
                  15'd0);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
   endtask

   // Address wrap at 32 bits: top and left go negative against the largest
   // frame, then the largest offsets meet a zero-sized frame, which counts
   // like a size of one.
   task automatic test_address_extremes();
      write_setup(pdb_pkg::MODE_PAL32, 32'hFFFF_FFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 16'd0,
                  16'd0, 15'd0);
      send_pixel(16'h0001);
      send_pixel(16'h00FF);
      write_setup(pdb_pkg::MODE_PAL32, 32'h0, 16'hFFFF, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF,
                  15'd0);
      send_pixel(16'h007F);
      send_pixel(16'h0000);
   endtask

   // A 3x2 frame wraps its counters. The base and pitch change in the middle
   // of the frame: the pitch takes effect at once, the base only at the next
   // frame.
   task automatic test_frame_wrap();
      write_setup(pdb_pkg::MODE_RAW16, 32'h0000_0100, 16'h0040, 12'd3, 12'd2, 16'd8,
                  16'd8, 15'd0);
      repeat (4) send_pixel(16'($urandom_range(65535)));
      write_setup(pdb_pkg::MODE_RAW16, 32'h0080_0000, 16'h0023, 12'd3, 12'd2, 16'd8,
                  16'd8, 15'd0);
      repeat (3) send_pixel(16'($urandom_range(65535)));
   endtask

   // The write side stops for a long stretch while pixels keep coming, so
   // the block fills and holds off its input. Then the sender waits until
   // every write is out before it goes on.
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_setup(pdb_pkg::MODE_PAL32, 32'h0010_0000, 16'h0100, 12'd4, 12'd3, 16'd2,
                  16'd2, 15'd0);
      @(posedge clock);
      rsp_hold_request = 120;
      @(negedge clock);
      repeat (12) send_pixel(pick_pixel_value());
      drain_writes(100000);
      repeat (4) send_pixel(pick_pixel_value());
   endtask

   // Mixed palette loads and pixels under one pacing, with a fresh random
   // setup at the start and halfway through.
   task automatic test_random_traffic(int count, int req_pct, int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      for (int n = 0; n < count; n++) begin
         if (n == 0 || n == count / 2) write_random_setup();
         if ($urandom_range(3) == 0)
            load_palette(8'($urandom_range(255)), $urandom);
         else
            send_pixel(pick_pixel_value());
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence. Reset is held at the start and never again.
   // The directed tests run under light pacing, then three random phases
   // swap which side idles more, and the last one runs flat out.
   // -------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset        = 1'b0;
      req_idle_pct = 10;
      rsp_idle_pct = 30;

      test_reset_configuration();
      test_palette_halfwords();
      test_color_conversion();
      test_address_extremes();
      test_frame_wrap();
      test_backpressure();
      test_random_traffic(26, 28, 85);
      test_random_traffic(26, 85, 28);
      test_random_traffic(26, 0, 0);

      // Anything still predicted after the settle time never came out.
      drain_writes(20000);
      if (expected_writes.size() != 0) begin
         fail_count += expected_writes.size();
         $display("%0d predicted writes never arrived", expected_writes.size());
      end
      if (fail_count == 0)
         $display("** pixel_doubler_blit_top: PASSED **");
      else
         $display("** pixel_doubler_blit_top: FAILED **");
      $finish;
   end

   // Watchdog for a block that hangs; far beyond the slowest correct run.
   initial begin
      #400000;
      $display("** pixel_doubler_blit_top: FAILED **");
      $finish;
   end

endmodule
